FILE: hdl/sat_pkg.sv
// Shared types and codes for the section address translate unit.
// No dependencies; used by the top level and the checker.
package sat_pkg;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_V2F  = 2'd1;
    localparam logic [1:0] KIND_F2V  = 2'd2;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 5;
    localparam int INDEX_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FORM
    } sat_state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [INDEX_W-1:0] entry_index;
        logic [ADDR_W-1:0] virt_start;
        logic [ADDR_W-1:0] virt_size;
        logic [ADDR_W-1:0] raw_start;
        logic [ADDR_W-1:0] raw_size;
        logic [ADDR_W-1:0] query_address;
    } sat_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] translated;
        logic              found;
    } sat_rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] virt_start;
        logic [ADDR_W-1:0] virt_size;
        logic [ADDR_W-1:0] raw_start;
        logic [ADDR_W-1:0] raw_size;
    } sat_entry_t;

endpackage

FILE: hdl/sat_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sat_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/section_address_translate_unit.sv
// Section address translate unit: section table in RAM plus a scan sequencer.
// Depends on sat_pkg and sat_ram.
//
// A load item writes one section entry; a load whose entry_index
// is MAX_SECTIONS or more is dropped, and kind 3 is dropped without a result.
// A lookup item scans the entries in use (min(section_count, MAX_SECTIONS)) in
// index order, one entry per cycle through the table RAM's registered read port,
// stops at the first entry holding the address, and then in ST_FORM adds the
// offset to the other space's start. A lookup holds the input stalled while it
// scans and forms its result; with no entries in use it goes straight to ST_FORM.
// A lookup also stays stalled while the previous result still sits in the output
// register, stalled downstream. The result waits in an output register, so the
// next item is taken while it is still stalled downstream.
// Entries must be loaded before a lookup scans them.
module section_address_translate_unit #(
    parameter int MAX_SECTIONS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sat_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sat_pkg::sat_req_t             req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sat_pkg::sat_rsp_t             rsp
);

    localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CW = $clog2(MAX_SECTIONS + 1);

    sat_pkg::sat_state_t              state_reg, state_next;
    logic [sat_pkg::COUNT_W-1:0]      section_count_reg;
    logic [CW-1:0]                    idx_reg, idx_next;
    logic [CW-1:0]                    limit_reg, limit_next;
    logic [1:0]                       kind_reg, kind_next;
    logic [sat_pkg::ADDR_W-1:0]       addr_reg, addr_next;
    logic [sat_pkg::ADDR_W-1:0]       offset_reg, offset_next;
    logic [sat_pkg::ADDR_W-1:0]       base_reg, base_next;
    logic                             hit_reg, hit_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    sat_pkg::sat_rsp_t                rsp_reg, rsp_next;

    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic [AW+sat_pkg::INDEX_W-1:0]   wr_addr_wide;
    logic [AW-1:0]                    rd_addr;
    sat_pkg::sat_entry_t              wr_entry, rd_entry;

    logic                             accept;
    logic [CW-1:0]                    limit_now;
    logic [CW-1:0]                    idx_inc;
    logic [sat_pkg::ADDR_W-1:0]       sel_start, sel_size, sel_other, sel_end;
    logic                             entry_hit;

    sat_ram #(
        .WIDTH ($bits(sat_pkg::sat_entry_t)),
        .DEPTH (MAX_SECTIONS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign accept       = req_valid && !req_stall;
    assign req_stall    = (state_reg != sat_pkg::ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

    assign wr_addr_wide = {{AW{1'b0}}, req.entry_index};
    assign wr_addr      = wr_addr_wide[AW-1:0];
    assign wr_en        = accept && (req.kind == sat_pkg::KIND_LOAD)
                          && ({28'd0, req.entry_index} < 32'(MAX_SECTIONS));
    assign wr_entry.virt_start = req.virt_start;
    assign wr_entry.virt_size  = req.virt_size;
    assign wr_entry.raw_start  = req.raw_start;
    assign wr_entry.raw_size   = req.raw_size;

    assign limit_now = (32'(section_count_reg) > 32'(MAX_SECTIONS))
                       ? CW'(MAX_SECTIONS) : CW'(section_count_reg);
    assign idx_inc   = idx_reg + CW'(1);

    // Entry under test: pick the range of the query's own space.
    always_comb
    begin
        if (kind_reg == sat_pkg::KIND_V2F)
        begin
            sel_start = rd_entry.virt_start;
            sel_size  = rd_entry.virt_size;
            sel_other = rd_entry.raw_start;
        end
        else
        begin
            sel_start = rd_entry.raw_start;
            sel_size  = rd_entry.raw_size;
            sel_other = rd_entry.virt_start;
        end
        sel_end   = sel_start + sel_size;
        entry_hit = (addr_reg >= sel_start) && (addr_reg < sel_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= sat_pkg::ST_IDLE;
            section_count_reg <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                section_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        limit_reg  <= limit_next;
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        offset_reg <= offset_next;
        base_reg   <= base_next;
        hit_reg    <= hit_next;
        rsp_reg    <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        offset_next    = offset_reg;
        base_next      = base_reg;
        hit_next       = hit_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_addr        = idx_reg[AW-1:0];

        unique case (state_reg)
            sat_pkg::ST_IDLE:
            begin
                if (accept && (req.kind == sat_pkg::KIND_V2F
                               || req.kind == sat_pkg::KIND_F2V))
                begin
                    kind_next   = req.kind;
                    addr_next   = req.query_address;
                    limit_next  = limit_now;
                    idx_next    = '0;
                    rd_addr     = '0;
                    hit_next    = 1'b0;
                    offset_next = '0;
                    base_next   = '0;
                    state_next  = (limit_now == '0) ? sat_pkg::ST_FORM : sat_pkg::ST_SCAN;
                end
            end
            sat_pkg::ST_SCAN:
            begin
                if (entry_hit)
                begin
                    hit_next    = 1'b1;
                    offset_next = addr_reg - sel_start;
                    base_next   = sel_other;
                    state_next  = sat_pkg::ST_FORM;
                end
                else if (idx_inc == limit_reg)
                begin
                    state_next = sat_pkg::ST_FORM;
                end
                else
                begin
                    // advance: fetch the next entry, its data lands next cycle
                    idx_next = idx_inc;
                    rd_addr  = idx_inc[AW-1:0];
                end
            end
            sat_pkg::ST_FORM:
            begin
                // hold the result until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.translated = hit_reg ? (offset_reg + base_reg) : '0;
                    rsp_next.found      = hit_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = sat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sat_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/sat_checker.sv
// Port-level checks for the section address translate unit, bound to the top level.
// Depends on sat_pkg.
module sat_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input sat_pkg::sat_req_t req,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input sat_pkg::sat_rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result item changed or dropped");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.translated == '0)
        else $error("miss with nonzero translated address");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall
        && (req.kind == sat_pkg::KIND_V2F || req.kind == sat_pkg::KIND_F2V)
        |=> req_stall)
        else $error("lookup item did not stall the input");

    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.kind == sat_pkg::KIND_LOAD |=> !req_stall)
        else $error("load item stalled the input");

    a_no_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall && !rsp_valid |=> !rsp_valid)
        else $error("result item appeared without a lookup in flight");

endmodule

bind section_address_translate_unit sat_checker u_sat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
